[rtl/assert_macros.svh]
// Assertion macros for the banded region hit test block.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BRHT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("brht assertion failed");
`define BRHT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("brht assertion failed");
`else
`define BRHT_ASSERT(lbl, clk, rst, prop)
`define BRHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/brht_pkg.sv]
// Shared types, sizes, operation codes and box helpers for the region block.
// No dependencies.
package brht_pkg;
   localparam int MAX_RECTS  = 256;
   localparam int ADDR_BITS  = $clog2(MAX_RECTS);
   localparam int CNT_BITS   = $clog2(MAX_RECTS + 1);
   localparam int COORD_BITS = 16;
   localparam int OP_BITS    = 3;

   localparam logic [OP_BITS-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_APPEND  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POINT   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_COVER   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_OVERLAP = 3'd4;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } box_type;

   localparam int BOX_BITS = $bits(box_type);

   function automatic logic box_empty(input box_type a);
      return (a.r <= a.l) || (a.b <= a.t);
   endfunction

   function automatic logic box_overlap(input box_type a, input box_type q);
      return !box_empty(a) && !box_empty(q) &&
             (a.l < q.r) && (q.l < a.r) && (a.t < q.b) && (q.t < a.b);
   endfunction
endpackage

[rtl/banded_region_hit_test_unit.sv]
// Banded region hit test: rectangle table in RAM, bounding box, band walk.
// Depends on brht_pkg, brht_ram and assert_macros.svh.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  request  | req_op req_x_lo req_y_lo req_x_hi ...  | start & !busy
//  response | rsp_answer rsp_status                  | rsp_strobe, one cycle
//
// Clear, append, unknown ops and queries decided by the bounding box are
// answered from the execute state, which registers the response beat.
// Table queries walk the table one entry per cycle, a rate set by the single
// read port of the table RAM.
// Synchronous reset empties the table at once; no clearing pass.
// One beat in flight at a time; the response side has no stall.
`include "assert_macros.svh"

module banded_region_hit_test_unit import brht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_BITS-1:0] req_op,
   input  coord_type          req_x_lo,
   input  coord_type          req_y_lo,
   input  coord_type          req_x_hi,
   input  coord_type          req_y_hi,
   output logic               rsp_strobe,
   output logic               rsp_answer,
   output logic               rsp_status
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [OP_BITS-1:0]  op_ff, op_in;
   box_type             q_ff, q_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   box_type             bbox_ff, bbox_in;
   logic [CNT_BITS-1:0] iss_ff, iss_in;
   logic                pend_ff, pend_in;
   logic                ph_ff, ph_in;
   coord_type           scan_ff, scan_in;
   logic                strobe_ff, strobe_in;
   logic                answer_ff, answer_in;
   logic                status_ff, status_in;

   logic                 mem_we;
   logic [BOX_BITS-1:0]  mem_rdata;
   box_type              e;
   logic                 skip, hit_done, hit_ans;
   coord_type            scan_nx;
   logic                 is_point, is_cover;

   brht_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_RECTS)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (cnt_ff[ADDR_BITS-1:0]),
      .wr_data (q_ff),
      .rd_addr (iss_ff[ADDR_BITS-1:0]),
      .rd_data (mem_rdata)
   );

   // per-entry band walk step
   always_comb begin
      e        = box_type'(mem_rdata);
      is_point = (op_ff == OP_POINT);
      is_cover = (op_ff == OP_COVER);
      hit_done = 1'b0;
      hit_ans  = 1'b0;
      scan_nx  = scan_ff;
      if (is_point) begin
         skip = !ph_ff && !(q_ff.t < e.b);
      end else begin
         skip = (e.b <= scan_ff);
      end
      if (!skip) begin
         if (is_point) begin
            if (q_ff.t < e.t) begin
               hit_done = 1'b1;
            end else if (!(e.r <= q_ff.l)) begin
               hit_done = 1'b1;
               hit_ans  = (e.l <= q_ff.l);
            end
         end else if (is_cover) begin
            if (scan_ff < e.t) begin
               hit_done = 1'b1;
            end else if (!(e.r <= q_ff.l)) begin
               if ((e.l <= q_ff.l) && (q_ff.r <= e.r)) begin
                  scan_nx = e.b;
                  if (q_ff.b <= e.b) begin
                     hit_done = 1'b1;
                     hit_ans  = 1'b1;
                  end
               end else begin
                  hit_done = 1'b1;
               end
            end
         end else begin
            if (q_ff.b <= e.t) begin
               hit_done = 1'b1;
            end else if (!(e.r <= q_ff.l)) begin
               if (q_ff.r <= e.l) begin
                  scan_nx = e.b;
                  if (q_ff.b <= e.b) begin
                     hit_done = 1'b1;
                  end
               end else begin
                  hit_done = 1'b1;
                  hit_ans  = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      bbox_in   = bbox_ff;
      iss_in    = iss_ff;
      pend_in   = 1'b0;
      ph_in     = ph_ff;
      scan_in   = scan_ff;
      strobe_in = 1'b0;
      answer_in = 1'b0;
      status_in = 1'b0;
      mem_we    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               q_in     = '{l: req_x_lo, t: req_y_lo, r: req_x_hi, b: req_y_hi};
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            iss_in  = '0;
            ph_in   = 1'b0;
            scan_in = q_ff.t;
            case (op_ff)
               OP_CLEAR: begin
                  cnt_in    = '0;
                  bbox_in   = '0;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
               OP_APPEND: begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
                  if (!box_empty(q_ff)) begin
                     if (cnt_ff >= CNT_BITS'(MAX_RECTS)) begin
                        status_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                        if (box_empty(bbox_ff)) begin
                           bbox_in = q_ff;
                        end else begin
                           if (q_ff.l < bbox_ff.l) bbox_in.l = q_ff.l;
                           if (q_ff.t < bbox_ff.t) bbox_in.t = q_ff.t;
                           if (q_ff.r > bbox_ff.r) bbox_in.r = q_ff.r;
                           if (q_ff.b > bbox_ff.b) bbox_in.b = q_ff.b;
                        end
                     end
                  end
               end
               OP_POINT: begin
                  if (box_empty(bbox_ff)) begin
                     strobe_in = 1'b1;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
               OP_COVER, OP_OVERLAP: begin
                  if (!box_overlap(bbox_ff, q_ff)) begin
                     strobe_in = 1'b1;
                     state_in  = ST_IDLE;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
               default: begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            endcase
         end
         ST_WALK: begin
            if (iss_ff < cnt_ff) begin
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               scan_in = scan_nx;
               if (!skip) ph_in = 1'b1;
            end
            if (pend_ff && hit_done) begin
               strobe_in = 1'b1;
               answer_in = hit_ans;
               state_in  = ST_IDLE;
               pend_in   = 1'b0;
            end else if (!pend_ff && !(iss_ff < cnt_ff)) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         bbox_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         bbox_ff   <= bbox_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      q_ff      <= q_in;
      iss_ff    <= iss_in;
      ph_ff     <= ph_in;
      scan_ff   <= scan_in;
      answer_ff <= answer_in;
      status_ff <= status_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_answer = answer_ff;
   assign rsp_status = status_ff;

   `BRHT_ASSERT(a_rsp_when_idle, clock, reset, rsp_strobe |-> !busy)
   `BRHT_ASSERT(a_accept_goes_busy, clock, reset, (start && !busy) |=> busy)
   `BRHT_ASSERT(a_full_no_answer, clock, reset, rsp_status |-> (rsp_strobe && !rsp_answer))
   `BRHT_ASSERT_ALWAYS(a_count_bound, clock, reset || (cnt_ff <= CNT_BITS'(MAX_RECTS)))
endmodule

[rtl/brht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module brht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
